@@ hw/rtl/tcc_pkg.sv @@
// Shared types, operation codes and constants for the tilt-compensated compass.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package tcc_pkg;

   // Operation codes: the controller's state and the datapath's command
   localparam int OpW = 5;
   typedef logic [OpW-1:0] op_type;

   localparam op_type OP_LOAD    = 5'd0;
   localparam op_type OP_SQ_AX   = 5'd1;
   localparam op_type OP_SQ_AY   = 5'd2;
   localparam op_type OP_SQ_AZ   = 5'd3;
   localparam op_type OP_SQ_MX   = 5'd4;
   localparam op_type OP_SQ_MY   = 5'd5;
   localparam op_type OP_SQ_MZ   = 5'd6;
   localparam op_type OP_SUMS    = 5'd7;
   localparam op_type OP_RT_A    = 5'd8;
   localparam op_type OP_RT_M    = 5'd9;
   localparam op_type OP_RT_H    = 5'd10;
   localparam op_type OP_RT_P    = 5'd11;
   localparam op_type OP_RT_WAIT = 5'd12;
   localparam op_type OP_PEAK    = 5'd13;
   localparam op_type OP_XY1     = 5'd14;
   localparam op_type OP_XY2     = 5'd15;
   localparam op_type OP_XY3     = 5'd16;
   localparam op_type OP_XY4     = 5'd17;
   localparam op_type OP_XY5     = 5'd18;
   localparam op_type OP_XY6     = 5'd19;
   localparam op_type OP_XY7     = 5'd20;
   localparam op_type OP_XY8     = 5'd21;
   localparam op_type OP_XY9     = 5'd22;
   localparam op_type OP_XY10    = 5'd23;
   localparam op_type OP_XY11    = 5'd24;
   localparam op_type OP_XY_CHK  = 5'd25;
   localparam op_type OP_CO_P    = 5'd26;
   localparam op_type OP_CO_R    = 5'd27;
   localparam op_type OP_CO_H    = 5'd28;
   localparam op_type OP_CO_WAIT = 5'd29;
   localparam op_type OP_FINISH  = 5'd30;

   // Square root unit: radicand width and one result bit per cycle
   localparam int RootSteps = 28;
   localparam int RadW      = 2 * RootSteps;

   // CORDIC operand and angle widths
   localparam int CordInW = 53;
   localparam int AngW    = 34;
   localparam int RotW    = 34;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic root_busy;
      logic cordic_busy;
      logic zero_norm;
      logic xy_zero;
      logic out_free;
   } stat_type;

   // atan(2^-i) in units of 2^32 per turn
   function automatic logic [31:0] atan_lut(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2E;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2F9;
         5'd15:   val = 32'h0000517C;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A2F;
         5'd19:   val = 32'h00000517;
         5'd20:   val = 32'h0000028B;
         5'd21:   val = 32'h00000145;
         5'd22:   val = 32'h000000A2;
         5'd23:   val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

@@ hw/rtl/tcc_sqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
// Depends on tcc_pkg for the radicand width.
`timescale 1ns / 1ps

module tcc_sqrt
   import tcc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RadW-1:0]   value,
   output logic              busy,
   output logic [RootSteps-1:0] root,
   output logic [RadW:0]     rem
);

   localparam int CntW = $clog2(RootSteps);

   logic [RadW:0]   v_ff, v_in;
   logic [RadW:0]   r_ff, r_in;
   logic [RadW:0]   b_ff, b_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [RadW:0]   trial;

   // one restoring step per cycle
   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = r_ff + b_ff;
      if (start) begin
         v_in    = {1'b0, value};
         r_in    = '0;
         b_in    = (RadW+1)'(1) << (2 * (RootSteps - 1));
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + b_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         b_in   = b_ff >> 2;
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(RootSteps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign root = r_ff[RootSteps-1:0];
   assign rem  = v_ff;

endmodule

@@ hw/rtl/tcc_cordic.sv @@
// Vectoring CORDIC atan2 with bit-at-a-time operand normalization.
// Depends on tcc_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module tcc_cordic
   import tcc_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [CordInW-1:0] x,
   input  logic signed [CordInW-1:0] y,
   output logic                      busy,
   output logic signed [AngW-1:0]    angle
);

   localparam int IterW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_NORM = 2'd1;
   localparam logic [1:0] PH_ROT  = 2'd2;

   logic [1:0]               ph_ff, ph_in;
   logic [CordInW-1:0]       ux_ff, ux_in, uy_ff, uy_in;
   logic                     xneg_ff, xneg_in, yneg_ff, yneg_in;
   logic signed [RotW-1:0]   xs_ff, xs_in, ys_ff, ys_in;
   logic signed [AngW-1:0]   z_ff, z_in;
   logic [IterW-1:0]         i_ff, i_in;
   logic [CordInW-1:0]       mx;
   logic signed [RotW-1:0]   xs0, ys0, dx, dy;
   logic signed [AngW-1:0]   step_ang;

   always_comb begin
      mx       = (ux_ff > uy_ff) ? ux_ff : uy_ff;
      xs0      = RotW'(ux_ff);
      ys0      = (yneg_ff && uy_ff != '0) ? -RotW'(uy_ff) : RotW'(uy_ff);
      dx       = ys_ff >>> i_ff;
      dy       = xs_ff >>> i_ff;
      step_ang = AngW'(atan_lut(5'(i_ff)));
   end

   // normalize, then rotate toward the x axis
   always_comb begin
      ph_in   = ph_ff;
      ux_in   = ux_ff;
      uy_in   = uy_ff;
      xneg_in = xneg_ff;
      yneg_in = yneg_ff;
      xs_in   = xs_ff;
      ys_in   = ys_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      if (start) begin
         ux_in   = x[CordInW-1] ? CordInW'(-x) : CordInW'(x);
         uy_in   = y[CordInW-1] ? CordInW'(-y) : CordInW'(y);
         xneg_in = x[CordInW-1];
         yneg_in = y[CordInW-1];
         z_in    = '0;
         ph_in   = PH_NORM;
      end else begin
         unique case (ph_ff)
            PH_NORM: begin
               if (mx == '0) begin
                  z_in  = '0;
                  ph_in = PH_IDLE;
               end else if (mx >= (CordInW'(1) << 30)) begin
                  ux_in = ux_ff >> 1;
                  uy_in = uy_ff >> 1;
               end else if (mx < (CordInW'(1) << 29)) begin
                  ux_in = ux_ff << 1;
                  uy_in = uy_ff << 1;
               end else begin
                  // left half plane: mirror and start from half a turn
                  if (xneg_ff && ux_ff != '0) begin
                     xs_in = xs0;
                     ys_in = -ys0;
                     z_in  = AngW'(1) <<< 31;
                  end else begin
                     xs_in = xs0;
                     ys_in = ys0;
                     z_in  = '0;
                  end
                  i_in  = '0;
                  ph_in = PH_ROT;
               end
            end
            PH_ROT: begin
               if (!ys_ff[RotW-1]) begin
                  xs_in = xs_ff + dx;
                  ys_in = ys_ff - dy;
                  z_in  = z_ff + step_ang;
               end else begin
                  xs_in = xs_ff - dx;
                  ys_in = ys_ff + dy;
                  z_in  = z_ff - step_ang;
               end
               if (i_ff == IterW'(CORDIC_STEPS - 1)) begin
                  ph_in = PH_IDLE;
               end else begin
                  i_in = i_ff + IterW'(1);
               end
            end
            default: ph_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
      end else begin
         ph_ff <= ph_in;
      end
      ux_ff   <= ux_in;
      uy_ff   <= uy_in;
      xneg_ff <= xneg_in;
      yneg_ff <= yneg_in;
      xs_ff   <= xs_in;
      ys_ff   <= ys_in;
      z_ff    <= z_in;
      i_ff    <= i_in;
   end

   assign busy  = (ph_ff != PH_IDLE);
   assign angle = z_ff;

endmodule

@@ hw/rtl/tcc_datapath.sv @@
// Compass datapath: sample registers, shared multiplier, square root, CORDIC,
// peak stores and result register. Depends on tcc_pkg, tcc_sqrt, tcc_cordic.
`timescale 1ns / 1ps

module tcc_datapath
   import tcc_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_mag_x,
   input  logic signed [15:0] req_mag_y,
   input  logic signed [15:0] req_mag_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_roll_angle,
   output logic [15:0]        rsp_heading_angle,
   output logic [15:0]        rsp_accel_norm_peak,
   output logic [15:0]        rsp_mag_norm_peak,
   output logic               rsp_degenerate
);

   localparam logic [1:0] RD_A = 2'd0;
   localparam logic [1:0] RD_M = 2'd1;
   localparam logic [1:0] RD_H = 2'd2;
   localparam logic [1:0] RD_P = 2'd3;

   localparam logic [1:0] CD_P = 2'd0;
   localparam logic [1:0] CD_R = 2'd1;
   localparam logic [1:0] CD_H = 2'd2;

   // sample words
   logic signed [15:0] ax_ff, ay_ff, az_ff, mx_ff, my_ff, mz_ff;
   // sums of squares, norms
   logic [31:0]        asq_ff, hsq_ff, msq_ff;
   logic [15:0]        an_ff, mn_ff, h_ff;
   logic [RootSteps-1:0] pf_ff;
   // products and horizontal field
   logic signed [52:0] prod_ff;
   logic signed [33:0] t0_ff, t1_ff, t2_ff;
   logic signed [52:0] xacc_ff, yacc_ff;
   // angles and flags
   logic signed [15:0] pitch_ff, roll_ff;
   logic [15:0]        head_ff;
   logic               degen_ff;
   logic [15:0]        apeak_ff, mpeak_ff;
   logic [1:0]         rdst_ff, cdst_ff;
   // result register
   logic               rvalid_ff;
   logic signed [15:0] rpitch_ff, rroll_ff;
   logic [15:0]        rhead_ff, rapeak_ff, rmpeak_ff;
   logic               rdegen_ff;

   logic signed [34:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [52:0] product;
   logic [16:0]        aaz;
   logic               hzero;
   logic               out_free;

   logic               root_start, root_busy;
   logic [RadW-1:0]    root_val;
   logic [RootSteps-1:0] root_r;
   logic [RadW:0]      root_rem;
   logic [RootSteps:0] root_rnd;

   logic               co_start, co_busy;
   logic signed [CordInW-1:0] co_x, co_y;
   logic signed [AngW-1:0] co_ang;
   logic signed [34:0] zr, hr;
   logic signed [18:0] zq;
   logic signed [15:0] half_ang;

   assign aaz      = az_ff[15] ? 17'(-(17'(az_ff))) : 17'(az_ff);
   assign hzero    = (hsq_ff == '0);
   assign out_free = !rvalid_ff || rsp_ready;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SQ_AX: begin mul_a = 35'(ax_ff); mul_b = 18'(ax_ff); end
         OP_SQ_AY: begin mul_a = 35'(ay_ff); mul_b = 18'(ay_ff); end
         OP_SQ_AZ: begin mul_a = 35'(az_ff); mul_b = 18'(az_ff); end
         OP_SQ_MX: begin mul_a = 35'(mx_ff); mul_b = 18'(mx_ff); end
         OP_SQ_MY: begin mul_a = 35'(my_ff); mul_b = 18'(my_ff); end
         OP_SQ_MZ: begin mul_a = 35'(mz_ff); mul_b = 18'(mz_ff); end
         OP_XY1:   begin mul_a = 35'(mx_ff); mul_b = $signed({2'b00, h_ff}); end
         OP_XY2:   begin mul_a = 35'(mz_ff); mul_b = 18'(ax_ff); end
         OP_XY3:   begin mul_a = 35'(mx_ff); mul_b = 18'(ay_ff); end
         OP_XY4:   begin
            mul_a = 35'(t0_ff) - 35'(t1_ff);
            mul_b = $signed({2'b00, h_ff});
         end
         OP_XY5:   begin mul_a = 35'(t2_ff); mul_b = 18'(ax_ff); end
         OP_XY6:   begin mul_a = 35'(my_ff); mul_b = $signed({1'b0, aaz}); end
         OP_XY7:   begin mul_a = 35'(mz_ff); mul_b = 18'(ay_ff); end
         OP_XY8:   begin mul_a = 35'(t2_ff); mul_b = $signed({2'b00, an_ff}); end
         OP_XY9:   begin mul_a = 35'(t1_ff); mul_b = $signed({2'b00, h_ff}); end
         OP_XY10:  begin mul_a = 35'(my_ff); mul_b = $signed({2'b00, an_ff}); end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign product = mul_a * mul_b;

   // square root operand and rounding
   always_comb begin
      root_start = 1'b0;
      root_val   = '0;
      case (cmd.op)
         OP_RT_A: begin root_start = 1'b1; root_val = RadW'(asq_ff); end
         OP_RT_M: begin root_start = 1'b1; root_val = RadW'(msq_ff); end
         OP_RT_H: begin root_start = 1'b1; root_val = RadW'(hsq_ff); end
         OP_RT_P: begin root_start = 1'b1; root_val = RadW'(hsq_ff) << 24; end
         default: begin root_start = 1'b0; root_val = '0; end
      endcase
      root_rnd = (RootSteps+1)'(root_r)
               + (RootSteps+1)'(root_rem > (RadW+1)'(root_r));
   end

   tcc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (root_val),
      .busy  (root_busy),
      .root  (root_r),
      .rem   (root_rem)
   );

   // CORDIC operand select
   always_comb begin
      co_start = 1'b0;
      co_x     = '0;
      co_y     = '0;
      case (cmd.op)
         OP_CO_P: begin
            co_start = 1'b1;
            co_x     = $signed(CordInW'(pf_ff));
            co_y     = -(CordInW'(ax_ff) <<< 12);
         end
         OP_CO_R: begin
            co_start = 1'b1;
            co_x     = $signed(CordInW'(aaz));
            co_y     = CordInW'(ay_ff);
         end
         OP_CO_H: begin
            co_start = 1'b1;
            co_x     = xacc_ff;
            co_y     = yacc_ff;
         end
         default: begin
            co_start = 1'b0;
            co_x     = '0;
            co_y     = '0;
         end
      endcase
   end

   tcc_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (co_start),
      .x     (co_x),
      .y     (co_y),
      .busy  (co_busy),
      .angle (co_ang)
   );

   // angle rounding: quarter turn saturation for tilt, full turn for heading
   always_comb begin
      zr = 35'(co_ang) + 35'sd32768;
      zq = zr[34:16];
      if (zq > 19'sd16384) begin
         half_ang = 16'sd16384;
      end else if (zq < -19'sd16384) begin
         half_ang = -16'sd16384;
      end else begin
         half_ang = 16'(zq);
      end
      hr = 35'sd32768 - 35'(co_ang);
   end

   // datapath registers, updated per command
   always_ff @(posedge clock) begin
      prod_ff <= product;
      case (cmd.op)
         OP_LOAD: begin
            ax_ff <= req_accel_x;
            ay_ff <= req_accel_y;
            az_ff <= req_accel_z;
            mx_ff <= req_mag_x;
            my_ff <= req_mag_y;
            mz_ff <= req_mag_z;
         end
         OP_SQ_AY: asq_ff <= 32'(prod_ff);
         OP_SQ_AZ: hsq_ff <= 32'(prod_ff);
         OP_SQ_MX: hsq_ff <= hsq_ff + 32'(prod_ff);
         OP_SQ_MY: msq_ff <= 32'(prod_ff);
         OP_SQ_MZ: msq_ff <= msq_ff + 32'(prod_ff);
         OP_SUMS: begin
            msq_ff <= msq_ff + 32'(prod_ff);
            asq_ff <= asq_ff + hsq_ff;
         end
         OP_RT_A:  rdst_ff <= RD_A;
         OP_RT_M:  rdst_ff <= RD_M;
         OP_RT_H:  rdst_ff <= RD_H;
         OP_RT_P:  rdst_ff <= RD_P;
         OP_RT_WAIT: begin
            if (!root_busy) begin
               unique case (rdst_ff)
                  RD_A:    an_ff <= 16'(root_rnd);
                  RD_M:    mn_ff <= 16'(root_rnd);
                  RD_H:    h_ff  <= 16'(root_rnd);
                  RD_P:    pf_ff <= root_r;
                  default: pf_ff <= root_r;
               endcase
            end
         end
         OP_PEAK: begin
            degen_ff <= (an_ff == '0) || (mn_ff == '0);
            pitch_ff <= '0;
            roll_ff  <= '0;
            head_ff  <= '0;
         end
         OP_XY2:  t0_ff <= 34'(prod_ff);
         OP_XY3:  t1_ff <= 34'(prod_ff);
         OP_XY4:  t2_ff <= 34'(prod_ff);
         OP_XY5:  xacc_ff <= hzero ? -(53'(t1_ff)) : prod_ff;
         OP_XY6:  yacc_ff <= -prod_ff;
         OP_XY7:  t2_ff <= 34'(prod_ff);
         OP_XY8:  t1_ff <= 34'(prod_ff);
         OP_XY9:  yacc_ff <= yacc_ff + prod_ff;
         OP_XY10: yacc_ff <= yacc_ff - prod_ff;
         OP_XY11: begin
            if (hzero) begin
               yacc_ff <= prod_ff;
            end
         end
         OP_XY_CHK: degen_ff <= (xacc_ff == '0) && (yacc_ff == '0);
         OP_CO_P: cdst_ff <= CD_P;
         OP_CO_R: cdst_ff <= CD_R;
         OP_CO_H: cdst_ff <= CD_H;
         OP_CO_WAIT: begin
            if (!co_busy) begin
               unique case (cdst_ff)
                  CD_P:    pitch_ff <= half_ang;
                  CD_R:    roll_ff  <= half_ang;
                  CD_H:    head_ff  <= hr[31:16];
                  default: head_ff  <= hr[31:16];
               endcase
            end
         end
         OP_FINISH: begin
            if (out_free) begin
               rpitch_ff <= pitch_ff;
               rroll_ff  <= roll_ff;
               rhead_ff  <= head_ff;
               rapeak_ff <= apeak_ff;
               rmpeak_ff <= mpeak_ff;
               rdegen_ff <= degen_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // peak stores and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         apeak_ff  <= '0;
         mpeak_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_PEAK) begin
            if (an_ff > apeak_ff) begin
               apeak_ff <= an_ff;
            end
            if (mn_ff > mpeak_ff) begin
               mpeak_ff <= mn_ff;
            end
         end
         if (cmd.op == OP_FINISH && out_free) begin
            rvalid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      stat.root_busy   = root_busy;
      stat.cordic_busy = co_busy;
      stat.zero_norm   = (an_ff == '0) || (mn_ff == '0);
      stat.xy_zero     = (xacc_ff == '0) && (yacc_ff == '0);
      stat.out_free    = out_free;
   end

   assign rsp_valid           = rvalid_ff;
   assign rsp_pitch_angle     = rpitch_ff;
   assign rsp_roll_angle      = rroll_ff;
   assign rsp_heading_angle   = rhead_ff;
   assign rsp_accel_norm_peak = rapeak_ff;
   assign rsp_mag_norm_peak   = rmpeak_ff;
   assign rsp_degenerate      = rdegen_ff;

endmodule

@@ hw/rtl/tcc_ctrl.sv @@
// Compass sequencer: steps the datapath through one sample word.
// Depends on tcc_pkg for the operation codes and the command/status types.
`timescale 1ns / 1ps

module tcc_ctrl
   import tcc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   op_type state_ff, state_in;
   op_type ret_ff, ret_in;

   // next state: straight sequence with early exits to finish, waits on the shared units
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         OP_LOAD:   if (req_valid) state_in = OP_SQ_AX;
         OP_SQ_AX:  state_in = OP_SQ_AY;
         OP_SQ_AY:  state_in = OP_SQ_AZ;
         OP_SQ_AZ:  state_in = OP_SQ_MX;
         OP_SQ_MX:  state_in = OP_SQ_MY;
         OP_SQ_MY:  state_in = OP_SQ_MZ;
         OP_SQ_MZ:  state_in = OP_SUMS;
         OP_SUMS:   state_in = OP_RT_A;
         OP_RT_A:   begin ret_in = OP_RT_M; state_in = OP_RT_WAIT; end
         OP_RT_M:   begin ret_in = OP_PEAK; state_in = OP_RT_WAIT; end
         OP_RT_H:   begin ret_in = OP_RT_P; state_in = OP_RT_WAIT; end
         OP_RT_P:   begin ret_in = OP_XY1;  state_in = OP_RT_WAIT; end
         OP_RT_WAIT: if (!stat.root_busy) state_in = ret_ff;
         OP_PEAK:   state_in = stat.zero_norm ? OP_FINISH : OP_RT_H;
         OP_XY1:    state_in = OP_XY2;
         OP_XY2:    state_in = OP_XY3;
         OP_XY3:    state_in = OP_XY4;
         OP_XY4:    state_in = OP_XY5;
         OP_XY5:    state_in = OP_XY6;
         OP_XY6:    state_in = OP_XY7;
         OP_XY7:    state_in = OP_XY8;
         OP_XY8:    state_in = OP_XY9;
         OP_XY9:    state_in = OP_XY10;
         OP_XY10:   state_in = OP_XY11;
         OP_XY11:   state_in = OP_XY_CHK;
         OP_XY_CHK: state_in = stat.xy_zero ? OP_FINISH : OP_CO_P;
         OP_CO_P:   begin ret_in = OP_CO_R;   state_in = OP_CO_WAIT; end
         OP_CO_R:   begin ret_in = OP_CO_H;   state_in = OP_CO_WAIT; end
         OP_CO_H:   begin ret_in = OP_FINISH; state_in = OP_CO_WAIT; end
         OP_CO_WAIT: if (!stat.cordic_busy) state_in = ret_ff;
         OP_FINISH: if (stat.out_free) state_in = OP_LOAD;
         default:   state_in = OP_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OP_LOAD;
         ret_ff   <= OP_LOAD;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   assign req_ready = (state_ff == OP_LOAD);
   assign cmd.op    = state_ff;

endmodule

@@ hw/rtl/tilt_compensated_compass.sv @@
// Tilt-compensated compass: pitch, roll, heading and norm peaks per sample word.
// Each word takes two square roots when a norm is zero, four otherwise; unless
// the word is degenerate, three CORDIC runs follow, each normalizing the
// operands and then rotating toward the x axis.
// One word in flight; the next is taken once the result register is loaded.
// Synchronous reset clears the sequencer, the result valid and both peaks.
`timescale 1ns / 1ps

module tilt_compensated_compass
   import tcc_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_mag_x,
   input  logic signed [15:0] req_mag_y,
   input  logic signed [15:0] req_mag_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_roll_angle,
   output logic [15:0]        rsp_heading_angle,
   output logic [15:0]        rsp_accel_norm_peak,
   output logic [15:0]        rsp_mag_norm_peak,
   output logic               rsp_degenerate
);

   cmd_type  cmd;
   stat_type stat;

   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   tcc_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .req_mag_x           (req_mag_x),
      .req_mag_y           (req_mag_y),
      .req_mag_z           (req_mag_z),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pitch_angle     (rsp_pitch_angle),
      .rsp_roll_angle      (rsp_roll_angle),
      .rsp_heading_angle   (rsp_heading_angle),
      .rsp_accel_norm_peak (rsp_accel_norm_peak),
      .rsp_mag_norm_peak   (rsp_mag_norm_peak),
      .rsp_degenerate      (rsp_degenerate)
   );

endmodule

@@ bench/tcc_checker.sv @@
// Result checker for the tilt-compensated compass: watches both channels,
// computes expected angles and norm peaks per accepted word, and compares.
// Depends on the port list of tilt_compensated_compass only.
`timescale 1ns / 1ps

module tcc_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_mag_x,
   input  logic signed [15:0] req_mag_y,
   input  logic signed [15:0] req_mag_z,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_pitch_angle,
   input  logic signed [15:0] rsp_roll_angle,
   input  logic [15:0]        rsp_heading_angle,
   input  logic [15:0]        rsp_accel_norm_peak,
   input  logic [15:0]        rsp_mag_norm_peak,
   input  logic               rsp_degenerate,
   output int                 fail_count,
   output int                 pending,
   output int                 result_count,
   output int                 degen_count
);

   localparam int CordicSteps = 16;

   typedef struct packed {
      logic [15:0] pitch;
      logic [15:0] roll;
      logic [15:0] heading;
      logic [15:0] a_peak;
      logic [15:0] m_peak;
      logic        degen;
   } compass_out_type;

   compass_out_type heading_queue[$];
   logic [15:0]     a_peak_q, m_peak_q;

   function automatic logic [31:0] atan_step(input int i);
      logic [31:0] tab [24];
      tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
              32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
              32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
      return tab[i];
   endfunction

   // floor square root, bit by bit
   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] near_root(input logic [63:0] v);
      logic [63:0] r;
      r = floor_root(v);
      if (v - r * r > r) r = r + 1;
      return r;
   endfunction

   // vectoring CORDIC, 2^32 per turn
   function automatic longint vector_angle(input longint x, input longint y);
      logic [63:0] ux, uy, m;
      longint xs, ys, z, dx, dy;
      ux = x < 0 ? -x : x;
      uy = y < 0 ? -y : y;
      m = ux > uy ? ux : uy;
      z = 0;
      if (m == 0) return 0;
      while (m >= (64'd1 << 30)) begin
         ux = ux >> 1; uy = uy >> 1; m = m >> 1;
      end
      while (m < (64'd1 << 29)) begin
         ux = ux << 1; uy = uy << 1; m = m << 1;
      end
      xs = x < 0 ? -longint'(ux) : longint'(ux);
      ys = y < 0 ? -longint'(uy) : longint'(uy);
      if (xs < 0) begin
         xs = -xs; ys = -ys; z = longint'(1) << 31;
      end
      for (int i = 0; i < CordicSteps; i++) begin
         dx = ys >>> i;
         dy = xs >>> i;
         if (ys >= 0) begin
            xs += dx; ys -= dy; z += longint'(atan_step(i));
         end else begin
            xs -= dx; ys += dy; z -= longint'(atan_step(i));
         end
      end
      return z;
   endfunction

   function automatic logic [15:0] half_angle(input longint z);
      longint v;
      v = (z + 32768) >>> 16;
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return v[15:0];
   endfunction

   // expected word for one sample set; updates the peaks
   function automatic compass_out_type predict_heading(input longint ax, input longint ay,
         input longint az, input longint mx, input longint my, input longint mz);
      compass_out_type o;
      logic [63:0] hsq, asq, msq, an, mn, hd;
      longint a, h, aaz, x, y, pf;
      o = '0;
      hsq = ay * ay + az * az;
      asq = ax * ax + hsq;
      msq = mx * mx + my * my + mz * mz;
      an = near_root(asq);
      mn = near_root(msq);
      if (an > a_peak_q) a_peak_q = an[15:0];
      if (mn > m_peak_q) m_peak_q = mn[15:0];
      if (an == 0 || mn == 0) begin
         o.degen = 1;
      end else begin
         a = an;
         h = near_root(hsq);
         aaz = az < 0 ? -az : az;
         if (hsq == 0) begin
            x = -mz * ax;
            y = my * a;
         end else begin
            x = h * (mx * h - mz * ax);
            y = -mx * ay * ax + my * aaz * a - mz * ay * h;
         end
         if (x == 0 && y == 0) begin
            o.degen = 1;
         end else begin
            pf = floor_root(hsq << 24);
            o.pitch = half_angle(vector_angle(pf, -ax * 4096));
            o.roll = half_angle(vector_angle(aaz, ay));
            hd = (64'd0 - 64'(vector_angle(x, y)) + 64'h8000) >> 16;
            o.heading = hd[15:0];
         end
      end
      o.a_peak = a_peak_q;
      o.m_peak = m_peak_q;
      return o;
   endfunction

   always @(posedge clock) begin
      compass_out_type got, want;
      if (reset) begin
         a_peak_q <= 0;
         m_peak_q <= 0;
         fail_count <= 0;
         result_count <= 0;
         degen_count <= 0;
         pending <= 0;
         heading_queue.delete();
      end else begin
         if (req_valid && req_ready)
            heading_queue.push_back(predict_heading(req_accel_x, req_accel_y, req_accel_z,
                                                    req_mag_x, req_mag_y, req_mag_z));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_pitch_angle, rsp_roll_angle, rsp_heading_angle,
                   rsp_accel_norm_peak, rsp_mag_norm_peak, rsp_degenerate};
            result_count <= result_count + 1;
            if (rsp_degenerate) degen_count <= degen_count + 1;
            if (heading_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result word %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = heading_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("mismatch (exp/act): pitch %0d/%0d roll %0d/%0d head %0d/%0d",
                        $signed(want.pitch), $signed(got.pitch), $signed(want.roll),
                        $signed(got.roll), want.heading, got.heading);
                     $display("   apk %0d/%0d mpk %0d/%0d deg %0b/%0b",
                        want.a_peak, got.a_peak, want.m_peak, got.m_peak,
                        want.degen, got.degen);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= heading_queue.size();
      end
   end

endmodule

@@ bench/tb.sv @@
// Testbench top for tilt_compensated_compass: drives sample words with random
// idling, pulls results with random stalls, and reports the verdict.
// Depends on tcc_checker.sv and the compass RTL.
`timescale 1ns / 1ps

module tb;

   localparam int RandomWords = 530;
   localparam int IdleLimit   = 20000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [15:0] req_accel_x = 0, req_accel_y = 0, req_accel_z = 0;
   logic signed [15:0] req_mag_x = 0, req_mag_y = 0, req_mag_z = 0;
   logic               rsp_valid, rsp_ready = 0;
   logic signed [15:0] rsp_pitch_angle, rsp_roll_angle;
   logic [15:0]        rsp_heading_angle, rsp_accel_norm_peak, rsp_mag_norm_peak;
   logic               rsp_degenerate;
   int                 fail_count, pending, result_count, degen_count;
   int                 idle_cycles;
   int                 calm;
   int                 sent;
   logic [15:0]        directed [25][6];

   tilt_compensated_compass dut (.*);
   tcc_checker checker_i (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // idling is off for a long stretch mid-run
   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 34);
   endfunction

   // receiver stalls at random
   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= !idle_now();
   end

   // watchdog on accepts
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog: nothing accepted for %0d cycles", IdleLimit);
         $display("[tilt_compensated_compass] ERROR");
         $finish;
      end
   end

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'($urandom_range(8) - 4);
         3: return 16'($urandom);
         default: return 16'($urandom_range(4000) - 2000);
      endcase
   endfunction

   // one sample word, held until accepted; valid drops only while idling
   task automatic send_samples(input logic [15:0] s [6]);
      if (idle_now()) begin
         req_valid <= 0;
         @(posedge clock);
         while (idle_now()) @(posedge clock);
      end
      req_valid <= 1;
      req_accel_x <= s[0]; req_accel_y <= s[1]; req_accel_z <= s[2];
      req_mag_x <= s[3]; req_mag_y <= s[4]; req_mag_z <= s[5];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   initial begin
      logic [15:0] s [6];
      calm = 0;
      sent = 0;
      // extremes, zero norms, vertical gravity, zero horizontal field, quadrants
      directed = '{
         '{0, 0, 0, 0, 0, 0},           '{0, 0, 1000, 0, 0, 0},
         '{0, 0, 0, 100, 0, 0},         '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
         '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
         '{1000, 0, 0, 0, 500, 300},    '{16'hFC18, 0, 0, 200, 0, 16'hFF00},
         '{1000, 0, 0, 0, 0, 0},        '{0, 0, 1000, 0, 0, 700},
         '{0, 0, 1000, 500, 0, 0},      '{0, 0, 1000, 0, 500, 0},
         '{0, 0, 1000, 16'hFE0C, 0, 0}, '{0, 0, 1000, 0, 16'hFE0C, 0},
         '{0, 0, 1000, 300, 300, 0},    '{0, 0, 1000, 300, 16'hFED4, 0},
         '{0, 0, 1000, 16'hFED4, 300, 0}, '{0, 0, 16'hFC18, 300, 200, 100},
         '{0, 1000, 0, 300, 200, 100},  '{0, 16'hFC18, 0, 300, 200, 100},
         '{700, 700, 1, 50, 60, 70},    '{16'h8000, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF},
         '{1, 1, 1, 1, 1, 1},           '{16'h7FFF, 0, 16'h8000, 0, 16'h7FFF, 0},
         '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
         '{5, 16'h8000, 3, 16'h8000, 2, 16'h7FFF}};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_samples(directed[i]);
      for (int n = 0; n < RandomWords; n++) begin
         calm = (n >= 200 && n < 280);
         for (int k = 0; k < 6; k++) s[k] = pick_sample();
         send_samples(s);
      end
      req_valid <= 0;
      calm = 0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d sample words, checked %0d results (%0d degenerate)",
               sent, result_count, degen_count);
      if (fail_count == 0) $display("[tilt_compensated_compass] OK");
      else $display("[tilt_compensated_compass] ERROR");
      $finish;
   end

endmodule

@@ tilt_compensated_compass.f @@
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_sqrt.sv
hw/rtl/tcc_cordic.sv
hw/rtl/tcc_datapath.sv
hw/rtl/tcc_ctrl.sv
hw/rtl/tilt_compensated_compass.sv
bench/tcc_checker.sv
bench/tb.sv
